// ===== rtl/segment_intersection_core_defines.svh =====
// assertion macros for the segment intersection core
// expect clk and rst_n in the scope of use; no other dependencies
`ifndef SEGMENT_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SEGINT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SEGINT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/segint_pkg.sv =====
// shared widths, types and the divider step for the segment intersection core
// no dependencies
package segint_pkg;

  localparam int CW = 24;            // coordinate width
  localparam int XW = 2 * CW + 3;    // cross product width, signed
  localparam int RW = XW + 1;        // divider remainder width
  localparam int PW = 2 * CW + 2;    // single product width, signed

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] cross_t;

  // one divider stage: both lanes share d and t
  typedef struct packed {
    logic          hit;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
    logic [XW-1:0] d;
    logic [XW-1:0] t;
    logic [CW-1:0] mag_x;
    logic [CW-1:0] mag_y;
    logic          neg_x;
    logic          neg_y;
    logic [CW-1:0] q_x;
    logic [CW-1:0] q_y;
    logic [RW-1:0] r_x;
    logic [RW-1:0] r_y;
  } div_stage_t;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [CW-1:0] q;
  } div_step_t;

  // one bit of floor(mag * t / d): r < d on entry, so the digit is 0, 1 or 2
  function automatic div_step_t div_step(logic [RW-1:0] r, logic [CW-1:0] q, logic b,
                                         logic [XW-1:0] t, logic [XW-1:0] d);
    logic [RW-1:0] acc;
    logic [RW-1:0] d1;
    logic [RW-1:0] d2;
    logic [CW-1:0] q2;
    div_step_t     res;
    acc = {r[RW-2:0], 1'b0} + (b ? RW'(t) : '0);
    d1  = RW'(d);
    d2  = {d1[RW-2:0], 1'b0};
    q2  = {q[CW-2:0], 1'b0};
    if (acc >= d2) begin
      res.r = acc - d2;
      res.q = q2 + CW'(2);
    end else if (acc >= d1) begin
      res.r = acc - d1;
      res.q = q2 + CW'(1);
    end else begin
      res.r = acc;
      res.q = q2;
    end
    return res;
  endfunction

endpackage

// ===== rtl/segment_intersection_core.sv =====
// segment intersection core: hit test and intersection point, fully pipelined
// depends on segint_pkg and segment_intersection_core_defines.svh
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | in_a_start_x .. in_b_end_y, 8 x 24b signed
//   out     | out_valid/out_stall | out_hit, out_cross_x, out_cross_y
//
// one segment pair per cycle while the output is not stalled
// the restoring divider for mag * t / d takes one quotient bit per stage
// the whole pipeline holds while a result sits stalled at the output register
// in_stall = out_valid & out_stall
// rst_n is synchronous and clears the valid bits only
`include "segment_intersection_core_defines.svh"

module segment_intersection_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [segint_pkg::CW-1:0] in_a_start_x,
  input  logic signed [segint_pkg::CW-1:0] in_a_start_y,
  input  logic signed [segint_pkg::CW-1:0] in_a_end_x,
  input  logic signed [segint_pkg::CW-1:0] in_a_end_y,
  input  logic signed [segint_pkg::CW-1:0] in_b_start_x,
  input  logic signed [segint_pkg::CW-1:0] in_b_start_y,
  input  logic signed [segint_pkg::CW-1:0] in_b_end_x,
  input  logic signed [segint_pkg::CW-1:0] in_b_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [segint_pkg::CW-1:0] out_cross_x,
  output logic signed [segint_pkg::CW-1:0] out_cross_y
);

  localparam int CW = segint_pkg::CW;
  localparam int XW = segint_pkg::XW;
  localparam int RW = segint_pkg::RW;

  logic adv;

  // stage 1: coordinate differences
  logic                s1_v_r;
  segint_pkg::diff_t   s1_dx12_r, s1_dy12_r, s1_dx13_r, s1_dy13_r, s1_dx34_r, s1_dy34_r;
  segint_pkg::coord_t  s1_x1_r, s1_y1_r;

  // stage 2: products, lerp direction
  logic                s2_v_r;
  segint_pkg::prod_t   s2_pd0_r, s2_pd1_r, s2_pt0_r, s2_pt1_r, s2_pu0_r, s2_pu1_r;
  segint_pkg::prod_t   pd0_nxt, pd1_nxt, pt0_nxt, pt1_nxt, pu0_nxt, pu1_nxt;
  segint_pkg::coord_t  s2_x1_r, s2_y1_r;
  logic [CW-1:0]       s2_mag_x_r, s2_mag_y_r;
  logic                s2_neg_x_r, s2_neg_y_r;
  segint_pkg::diff_t   abs_x, abs_y;

  // stage 3: d, t, u
  logic                s3_v_r;
  segint_pkg::cross_t  s3_d_r, s3_t_r, s3_u_r;
  segint_pkg::coord_t  s3_x1_r, s3_y1_r;
  logic [CW-1:0]       s3_mag_x_r, s3_mag_y_r;
  logic                s3_neg_x_r, s3_neg_y_r;

  // stage 4: sign normalized so d >= 0
  logic                s4_v_r;
  segint_pkg::cross_t  s4_d_r, s4_t_r, s4_u_r;
  segint_pkg::coord_t  s4_x1_r, s4_y1_r;
  logic [CW-1:0]       s4_mag_x_r, s4_mag_y_r;
  logic                s4_neg_x_r, s4_neg_y_r;
  logic                hit_nxt;

  // divider stages
  logic                   div_v_r [0:CW];
  segint_pkg::div_stage_t div_r   [0:CW];

  // output register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [CW-1:0]       out_x_r, out_y_r;
  logic [CW-1:0]       out_x_nxt, out_y_nxt;

  // assertion terms
  logic                zero_d_adv, tail_hit, rem_ok, quot_ok, miss_pt_zero;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= CW; k++) begin
        div_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      div_v_r[0]  <= s4_v_r;
      for (int k = 0; k < CW; k++) begin
        div_v_r[k+1] <= div_v_r[k];
      end
      out_valid_r <= div_v_r[CW];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx12_r <= segint_pkg::diff_t'(in_a_start_x) - segint_pkg::diff_t'(in_a_end_x);
      s1_dy12_r <= segint_pkg::diff_t'(in_a_start_y) - segint_pkg::diff_t'(in_a_end_y);
      s1_dx13_r <= segint_pkg::diff_t'(in_a_start_x) - segint_pkg::diff_t'(in_b_start_x);
      s1_dy13_r <= segint_pkg::diff_t'(in_a_start_y) - segint_pkg::diff_t'(in_b_start_y);
      s1_dx34_r <= segint_pkg::diff_t'(in_b_start_x) - segint_pkg::diff_t'(in_b_end_x);
      s1_dy34_r <= segint_pkg::diff_t'(in_b_start_y) - segint_pkg::diff_t'(in_b_end_y);
      s1_x1_r   <= in_a_start_x;
      s1_y1_r   <= in_a_start_y;
    end
  end

  // stage 2
  assign pd0_nxt = s1_dx12_r * s1_dy34_r;
  assign pd1_nxt = s1_dy12_r * s1_dx34_r;
  assign pt0_nxt = s1_dx13_r * s1_dy34_r;
  assign pt1_nxt = s1_dy13_r * s1_dx34_r;
  assign pu0_nxt = s1_dx13_r * s1_dy12_r;
  assign pu1_nxt = s1_dy13_r * s1_dx12_r;
  assign abs_x   = s1_dx12_r[CW] ? -s1_dx12_r : s1_dx12_r;
  assign abs_y   = s1_dy12_r[CW] ? -s1_dy12_r : s1_dy12_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pd0_r   <= pd0_nxt;
      s2_pd1_r   <= pd1_nxt;
      s2_pt0_r   <= pt0_nxt;
      s2_pt1_r   <= pt1_nxt;
      s2_pu0_r   <= pu0_nxt;
      s2_pu1_r   <= pu1_nxt;
      s2_x1_r    <= s1_x1_r;
      s2_y1_r    <= s1_y1_r;
      s2_mag_x_r <= abs_x[CW-1:0];
      s2_mag_y_r <= abs_y[CW-1:0];
      // delta = end - start = -(start - end)
      s2_neg_x_r <= !s1_dx12_r[CW] && (s1_dx12_r != '0);
      s2_neg_y_r <= !s1_dy12_r[CW] && (s1_dy12_r != '0);
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_d_r     <= segint_pkg::cross_t'(s2_pd0_r) - segint_pkg::cross_t'(s2_pd1_r);
      s3_t_r     <= segint_pkg::cross_t'(s2_pt0_r) - segint_pkg::cross_t'(s2_pt1_r);
      s3_u_r     <= segint_pkg::cross_t'(s2_pu0_r) - segint_pkg::cross_t'(s2_pu1_r);
      s3_x1_r    <= s2_x1_r;
      s3_y1_r    <= s2_y1_r;
      s3_mag_x_r <= s2_mag_x_r;
      s3_mag_y_r <= s2_mag_y_r;
      s3_neg_x_r <= s2_neg_x_r;
      s3_neg_y_r <= s2_neg_y_r;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_d_r[XW-1]) begin
        s4_d_r <= -s3_d_r;
        s4_t_r <= -s3_t_r;
        s4_u_r <= -s3_u_r;
      end else begin
        s4_d_r <= s3_d_r;
        s4_t_r <= s3_t_r;
        s4_u_r <= s3_u_r;
      end
      s4_x1_r    <= s3_x1_r;
      s4_y1_r    <= s3_y1_r;
      s4_mag_x_r <= s3_mag_x_r;
      s4_mag_y_r <= s3_mag_y_r;
      s4_neg_x_r <= s3_neg_x_r;
      s4_neg_y_r <= s3_neg_y_r;
    end
  end

  // 0 <= t/d <= 1 and 0 <= u/d <= 1, endpoints included
  assign hit_nxt = (s4_d_r != '0) && !s4_t_r[XW-1] && !s4_u_r[XW-1]
                   && (s4_d_r >= s4_t_r) && (s4_d_r >= s4_u_r);

  // stage 5: load the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0].hit   <= hit_nxt;
      div_r[0].x1    <= s4_x1_r;
      div_r[0].y1    <= s4_y1_r;
      div_r[0].d     <= s4_d_r;
      div_r[0].t     <= s4_t_r;
      div_r[0].mag_x <= s4_mag_x_r;
      div_r[0].mag_y <= s4_mag_y_r;
      div_r[0].neg_x <= s4_neg_x_r;
      div_r[0].neg_y <= s4_neg_y_r;
      div_r[0].q_x   <= '0;
      div_r[0].q_y   <= '0;
      div_r[0].r_x   <= '0;
      div_r[0].r_y   <= '0;
    end
  end

  // one quotient bit per stage, msb of the magnitude first
  for (genvar k = 0; k < CW; k++) begin : g_div
    segint_pkg::div_step_t  step_x, step_y;
    segint_pkg::div_stage_t stage_nxt;

    always_comb begin
      step_x = segint_pkg::div_step(div_r[k].r_x, div_r[k].q_x, div_r[k].mag_x[CW-1-k],
                                    div_r[k].t, div_r[k].d);
      step_y = segint_pkg::div_step(div_r[k].r_y, div_r[k].q_y, div_r[k].mag_y[CW-1-k],
                                    div_r[k].t, div_r[k].d);
      stage_nxt     = div_r[k];
      stage_nxt.r_x = step_x.r;
      stage_nxt.q_x = step_x.q;
      stage_nxt.r_y = step_y.r;
      stage_nxt.q_y = step_y.q;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k+1] <= stage_nxt;
      end
    end
  end

  // output stage: start +/- quotient, zero on a miss
  always_comb begin
    out_x_nxt = '0;
    out_y_nxt = '0;
    if (div_r[CW].hit) begin
      out_x_nxt = div_r[CW].neg_x ? (div_r[CW].x1 - div_r[CW].q_x)
                                  : (div_r[CW].x1 + div_r[CW].q_x);
      out_y_nxt = div_r[CW].neg_y ? (div_r[CW].y1 - div_r[CW].q_y)
                                  : (div_r[CW].y1 + div_r[CW].q_y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= div_r[CW].hit;
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

  assign zero_d_adv   = s4_v_r && adv && (s4_d_r == '0);
  assign tail_hit     = div_v_r[CW] && div_r[CW].hit;
  assign rem_ok       = (div_r[CW].r_x < RW'(div_r[CW].d))
                        && (div_r[CW].r_y < RW'(div_r[CW].d));
  assign quot_ok      = (div_r[CW].q_x <= div_r[CW].mag_x)
                        && (div_r[CW].q_y <= div_r[CW].mag_y);
  assign miss_pt_zero = (out_x_r == '0) && (out_y_r == '0);

  // parallel or collinear pairs never reach the divider as a hit
  `SEGINT_ASSERT_NEXT(a_zero_d_miss, zero_d_adv, !div_r[0].hit, "zero d flagged as hit")
  // remainder is below d at the last divider stage for a hit
  `SEGINT_ASSERT_IMP(a_rem_below_d, tail_hit, rem_ok, "divider remainder not below d")
  // t <= d keeps each quotient within the segment extent
  `SEGINT_ASSERT_IMP(a_quot_in_range, tail_hit, quot_ok, "quotient beyond segment extent")
  // a miss carries a zero point
  `SEGINT_ASSERT_IMP(a_miss_zero, out_valid_r && !out_hit_r, miss_pt_zero, "miss with nonzero point")

endmodule
